// File: src/mlfq_pkg.sv
// shared types and constants of the multilevel feedback queue scheduler
// no dependencies
package mlfq_pkg;

  localparam int LEVELS  = 16;
  localparam int THREADS = 64;
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int TID_W   = 6;
  localparam int TIME_W  = 64;
  localparam int STAT_W  = 2;
  localparam int ATTR_W  = LVL_W + STAT_W;
  localparam int PADDR_W = 3;

  typedef enum logic [2:0] {
    CMD_ENQUEUE  = 3'd0,
    CMD_DROP     = 3'd1,
    CMD_PREEMPT  = 3'd2,
    CMD_YIELD    = 3'd3,
    CMD_SET_WAKE = 3'd4
  } cmd_e;

  localparam logic [STAT_W-1:0] STAT_READY   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RUNNING = 2'd1;

  localparam logic [PADDR_W-1:0] ADDR_IDLE_ID = 3'd0;

  localparam logic RES_DONE     = 1'b0;
  localparam logic RES_REJECTED = 1'b1;

endpackage

// File: src/mlfq_if.sv
// request and response channel interfaces of the scheduler
// depends on mlfq_pkg
interface mlfq_req_if import mlfq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              cmd;
  logic [TID_W-1:0]        thread_id;
  logic [TIME_W-1:0]       now_ns;
  logic [TIME_W-1:0]       wake_ns;
  logic [STAT_W-1:0]       yield_status;

  modport source (output valid, cmd, thread_id, now_ns, wake_ns, yield_status,
                  input ready);
  modport sink   (input valid, cmd, thread_id, now_ns, wake_ns, yield_status,
                  output ready);
endinterface

interface mlfq_rsp_if import mlfq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TID_W-1:0] picked_id;
  logic             picked_idle;
  logic             result_code;

  modport source (output valid, picked_id, picked_idle, result_code, input ready);
  modport sink   (input valid, picked_id, picked_idle, result_code, output ready);
endinterface

// File: src/mlfq_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/mlfq_thread_scheduler.sv
// multilevel feedback queue scheduler top level: sequencer, level table, apb port
// depends on mlfq_pkg, mlfq_if, mlfq_ram
// sequence: enqueue, drop and set wake pass through the attribute state; preempt and yield
//   then walk the levels and each level's threads, and a match adds the attribute write
// throughput: one request at a time, taken only in the idle state with no response pending;
//   the pick walks the wake and link memories through their single shared read address
// reset: all threads unqueued, levels empty, wake and priority read as zero
//   through per-thread valid bits, current thread and idle id zero; no clearing pass
module mlfq_thread_scheduler import mlfq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  mlfq_req_if.sink           req_i,
  mlfq_rsp_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_ATTR, S_LVL, S_CHK, S_PATTR
  } state_e;

  state_e              st_q;
  logic [2:0]          cmd_q;
  logic [TID_W-1:0]    tid_q, cur_q, idle_q, sc_q, prev_q, a_addr_q;
  logic [TIME_W-1:0]   now_q, wake_q;
  logic [STAT_W-1:0]   ystat_q;
  logic [LVL_W-1:0]    lvl_q;
  logic                hasprev_q;
  logic [TID_W-1:0]    head_q [LEVELS];
  logic [TID_W-1:0]    tail_q [LEVELS];
  logic [LEVELS-1:0]   nonempty_q;
  logic [THREADS-1:0]  queued_q, wvld_q, avld_q;
  logic                ov_q, oidle_q, ocode_q;
  logic [TID_W-1:0]    oid_q;

  // memory ports
  logic                w_we, n_we, a_we;
  logic [TID_W-1:0]    w_waddr, n_waddr, rd_addr, a_raddr;
  logic [TIME_W-1:0]   w_wdata, w_rdata, wake_rd;
  logic [TID_W-1:0]    n_wdata, n_rdata;
  logic [ATTR_W-1:0]   a_wdata, a_rdata;
  logic [LVL_W-1:0]    lvl_rd, lvl_inc, app_lvl;
  logic                is_pick, due, last, take;

  mlfq_ram #(.WIDTH(TIME_W), .DEPTH(THREADS)) u_wake (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(rd_addr), .rdata_o(w_rdata)
  );
  mlfq_ram #(.WIDTH(TID_W), .DEPTH(THREADS)) u_next (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .raddr_i(rd_addr), .rdata_o(n_rdata)
  );
  mlfq_ram #(.WIDTH(ATTR_W), .DEPTH(THREADS)) u_attr (
    .clk_i, .we_i(a_we), .waddr_i(a_addr_q), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  // apb register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_IDLE_ID) ? {{(32-TID_W){1'b0}}, idle_q} : 32'd0;

  // handshake
  assign take        = req_i.valid && req_i.ready;
  assign req_i.ready = (st_q == S_IDLE) && (!ov_q || rsp_o.ready);
  assign rsp_o.valid       = ov_q;
  assign rsp_o.picked_id   = oid_q;
  assign rsp_o.picked_idle = oidle_q;
  assign rsp_o.result_code = ocode_q;

  // read values, never-written entries read as zero
  assign lvl_rd  = avld_q[a_addr_q] ? a_rdata[ATTR_W-1:STAT_W] : '0;
  assign wake_rd = wvld_q[sc_q] ? w_rdata : '0;
  assign is_pick = (cmd_q == CMD_PREEMPT) || (cmd_q == CMD_YIELD);
  assign lvl_inc = (lvl_rd == LVL_W'(LEVELS - 1)) ? lvl_rd : lvl_rd + 1'b1;
  assign app_lvl = (cmd_q == CMD_ENQUEUE) ? '0 : lvl_rd;
  assign due     = wake_rd < now_q;
  assign last    = sc_q == tail_q[lvl_q];

  // read addresses
  always_comb begin
    if (st_q == S_IDLE) begin
      a_raddr = ((req_i.cmd == CMD_PREEMPT) || (req_i.cmd == CMD_YIELD)) ?
                cur_q : req_i.thread_id;
    end else begin
      a_raddr = sc_q;
    end
    rd_addr = (st_q == S_LVL) ? head_q[lvl_q] : n_rdata;
  end

  // memory writes
  always_comb begin
    w_we    = 1'b0;
    w_waddr = tid_q;
    w_wdata = wake_q;
    n_we    = 1'b0;
    n_waddr = tail_q[app_lvl];
    n_wdata = tid_q;
    a_we    = 1'b0;
    a_wdata = {lvl_rd, STAT_READY};
    unique case (st_q)
      S_ATTR: begin
        case (cmd_q)
          CMD_ENQUEUE: begin
            a_we = !queued_q[tid_q];
            n_we = !queued_q[tid_q] && nonempty_q[app_lvl];
          end
          CMD_DROP: begin
            n_we = (tid_q != idle_q) && !queued_q[tid_q] && nonempty_q[app_lvl];
          end
          CMD_PREEMPT: begin
            a_we    = 1'b1;
            a_wdata = {lvl_inc, STAT_READY};
          end
          CMD_YIELD: begin
            a_we    = 1'b1;
            a_wdata = {lvl_rd, ystat_q};
          end
          CMD_SET_WAKE: w_we = 1'b1;
          default: ;
        endcase
      end
      S_CHK: begin
        n_waddr = prev_q;
        n_wdata = n_rdata;
        n_we    = due && hasprev_q && !last;
      end
      S_PATTR: begin
        a_we    = 1'b1;
        a_wdata = {lvl_rd, STAT_RUNNING};
      end
      default: ;
    endcase
  end

  // level heads and tails carry no reset
  always_ff @(posedge clk_i) begin
    if (st_q == S_ATTR && !queued_q[tid_q] &&
        (cmd_q == CMD_ENQUEUE || (cmd_q == CMD_DROP && tid_q != idle_q))) begin
      if (!nonempty_q[app_lvl]) head_q[app_lvl] <= tid_q;
      tail_q[app_lvl] <= tid_q;
    end else if (st_q == S_CHK && due) begin
      if (!hasprev_q && !last) head_q[lvl_q] <= n_rdata;
      if (hasprev_q && last)   tail_q[lvl_q] <= prev_q;
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      cur_q      <= '0;
      idle_q     <= '0;
      nonempty_q <= '0;
      queued_q   <= '0;
      wvld_q     <= '0;
      avld_q     <= '0;
      ov_q       <= 1'b0;
      oid_q      <= '0;
      oidle_q    <= 1'b0;
      ocode_q    <= RES_DONE;
      cmd_q      <= '0;
      tid_q      <= '0;
      now_q      <= '0;
      wake_q     <= '0;
      ystat_q    <= '0;
      lvl_q      <= '0;
      sc_q       <= '0;
      prev_q     <= '0;
      hasprev_q  <= 1'b0;
      a_addr_q   <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == ADDR_IDLE_ID) begin
        idle_q <= pwdata[TID_W-1:0];
      end
      if (ov_q && rsp_o.ready) ov_q <= 1'b0;
      if (a_we) avld_q[a_addr_q] <= 1'b1;
      unique case (st_q)
        S_IDLE: begin
          if (take) begin
            cmd_q    <= req_i.cmd;
            tid_q    <= req_i.thread_id;
            now_q    <= req_i.now_ns;
            wake_q   <= req_i.wake_ns;
            ystat_q  <= req_i.yield_status;
            a_addr_q <= a_raddr;
            st_q     <= S_ATTR;
          end
        end
        S_ATTR: begin
          oid_q   <= '0;
          oidle_q <= 1'b0;
          ocode_q <= RES_DONE;
          lvl_q   <= '0;
          if (is_pick) begin
            st_q <= S_LVL;
          end else begin
            ov_q <= 1'b1;
            st_q <= S_IDLE;
            if ((cmd_q == CMD_ENQUEUE || (cmd_q == CMD_DROP && tid_q != idle_q))) begin
              if (queued_q[tid_q]) begin
                ocode_q <= RES_REJECTED;
              end else begin
                nonempty_q[app_lvl] <= 1'b1;
                queued_q[tid_q]     <= 1'b1;
                if (cmd_q == CMD_ENQUEUE) wvld_q[tid_q] <= 1'b0;
              end
            end
            if (cmd_q == CMD_SET_WAKE) wvld_q[tid_q] <= 1'b1;
          end
        end
        S_LVL: begin
          if (nonempty_q[lvl_q]) begin
            sc_q      <= head_q[lvl_q];
            hasprev_q <= 1'b0;
            st_q      <= S_CHK;
          end else if (lvl_q == LVL_W'(LEVELS - 1)) begin
            oid_q   <= idle_q;
            oidle_q <= 1'b1;
            cur_q   <= idle_q;
            ov_q    <= 1'b1;
            st_q    <= S_IDLE;
          end else begin
            lvl_q <= lvl_q + 1'b1;
          end
        end
        S_CHK: begin
          if (due) begin
            if (!hasprev_q && last) nonempty_q[lvl_q] <= 1'b0;
            queued_q[sc_q] <= 1'b0;
            a_addr_q       <= sc_q;
            st_q           <= S_PATTR;
          end else if (last) begin
            if (lvl_q == LVL_W'(LEVELS - 1)) begin
              oid_q   <= idle_q;
              oidle_q <= 1'b1;
              cur_q   <= idle_q;
              ov_q    <= 1'b1;
              st_q    <= S_IDLE;
            end else begin
              lvl_q <= lvl_q + 1'b1;
              st_q  <= S_LVL;
            end
          end else begin
            prev_q    <= sc_q;
            hasprev_q <= 1'b1;
            sc_q      <= n_rdata;
          end
        end
        S_PATTR: begin
          oid_q <= sc_q;
          cur_q <= sc_q;
          ov_q  <= 1'b1;
          st_q  <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // a thread walked during a pick is always on a queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CHK) |-> queued_q[sc_q])
    else $error("pick walked an unqueued thread");

  // a rejected request never carries a pick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ocode_q) |-> (!oidle_q && oid_q == '0))
    else $error("rejected request carries a pick");

  // an accepted request leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (st_q == S_ATTR))
    else $error("request accepted without starting");

  // a matched thread becomes current when its response appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PATTR) |=> (ov_q && cur_q == oid_q && !oidle_q))
    else $error("picked thread not made current");

endmodule

// File: tb/mlfq_thread_scheduler_tb.sv
// self-checking testbench of the multilevel feedback queue scheduler: directed table,
// then random scheduling traffic checked against a behavioral scheduler model
// depends on mlfq_pkg, mlfq_if and mlfq_thread_scheduler
module mlfq_thread_scheduler_tb;
  import mlfq_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  mlfq_req_if req_if ();
  mlfq_rsp_if rsp_if ();

  mlfq_thread_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [2:0]        cmd;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] wake;
    logic [STAT_W-1:0] ystat;
  } sched_req_t;

  typedef struct packed {
    logic [TID_W-1:0] picked;
    logic             idle;
    logic             code;
  } sched_rsp_t;

  // scheduler state mirror
  logic [LVL_W-1:0]  prio_q [THREADS];
  logic [TIME_W-1:0] wake_q [THREADS];
  logic [TID_W-1:0]  link_q [THREADS];
  logic              queued_q [THREADS];
  logic [STAT_W-1:0] status_q [THREADS];
  logic [TID_W-1:0]  head_q [LEVELS];
  logic [TID_W-1:0]  tail_q [LEVELS];
  logic              busy_lvl_q [LEVELS];
  logic [TID_W-1:0]  running_q;
  logic [TID_W-1:0]  idle_tid;

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  int errors = 0;
  int idle_cycles = 0;
  int rsp_count = 0;
  bit long_hold = 0;
  bit rx_enable = 0;
  localparam int WATCHDOG = 20000;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (response %0d)", what, got, want, rsp_count);
    errors++;
  endtask

  function automatic void model_reset();
    for (int i = 0; i < THREADS; i++) begin
      prio_q[i] = '0; wake_q[i] = '0; link_q[i] = '0;
      queued_q[i] = 0; status_q[i] = STAT_READY;
    end
    for (int l = 0; l < LEVELS; l++) begin
      head_q[l] = '0; tail_q[l] = '0; busy_lvl_q[l] = 0;
    end
    running_q = '0;
    idle_tid = '0;
  endfunction

  function automatic void append_thread(int lvl, logic [TID_W-1:0] t);
    if (busy_lvl_q[lvl]) link_q[tail_q[lvl]] = t;
    else begin
      head_q[lvl] = t;
      busy_lvl_q[lvl] = 1;
    end
    tail_q[lvl] = t;
    queued_q[t] = 1;
  endfunction

  // walk levels in order, unlink the first thread that is due
  function automatic bit pick_due(logic [TIME_W-1:0] now, output logic [TID_W-1:0] chosen);
    logic [TID_W-1:0] cur, prev;
    bit has_prev, last;
    chosen = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (!busy_lvl_q[l]) continue;
      cur = head_q[l];
      has_prev = 0;
      prev = '0;
      for (int s = 0; s < THREADS; s++) begin
        if (wake_q[cur] < now) begin
          last = (cur == tail_q[l]);
          if (!has_prev) begin
            if (last) busy_lvl_q[l] = 0;
            else head_q[l] = link_q[cur];
          end else begin
            if (last) tail_q[l] = prev;
            else link_q[prev] = link_q[cur];
          end
          queued_q[cur] = 0;
          status_q[cur] = STAT_RUNNING;
          chosen = cur;
          return 1;
        end
        if (cur == tail_q[l]) break;
        prev = cur;
        has_prev = 1;
        cur = link_q[cur];
      end
    end
    return 0;
  endfunction

  function automatic sched_rsp_t schedule_step(sched_req_t r);
    sched_rsp_t o;
    logic [TID_W-1:0] chosen;
    o = '0;
    case (r.cmd)
      CMD_ENQUEUE: begin
        if (queued_q[r.tid]) o.code = RES_REJECTED;
        else begin
          wake_q[r.tid] = '0;
          status_q[r.tid] = STAT_READY;
          append_thread(0, r.tid);
        end
      end
      CMD_DROP: begin
        if (r.tid != idle_tid) begin
          if (queued_q[r.tid]) o.code = RES_REJECTED;
          else append_thread(prio_q[r.tid], r.tid);
        end
      end
      CMD_PREEMPT, CMD_YIELD: begin
        if (r.cmd == CMD_PREEMPT) begin
          status_q[running_q] = STAT_READY;
          if (prio_q[running_q] != LEVELS - 1) prio_q[running_q]++;
        end else status_q[running_q] = r.ystat;
        if (!pick_due(r.now, chosen)) begin
          chosen = idle_tid;
          o.idle = 1;
        end
        running_q = chosen;
        o.picked = chosen;
      end
      CMD_SET_WAKE: wake_q[r.tid] = r.wake;
      default: ;
    endcase
    return o;
  endfunction

  // apb register write, only when the block is idle
  task automatic write_idle_id(input logic [TID_W-1:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_IDLE_ID; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    idle_tid = v;
  endtask

  task automatic drain();
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (2 + LEVELS + THREADS + 10) @(posedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic sched_req_t rand_req();
    sched_req_t r;
    int k;
    r.tid = ($urandom_range(0, 3) == 0) ? TID_W'($urandom) : TID_W'($urandom_range(0, 11));
    r.now = rand_time();
    r.wake = rand_time();
    r.ystat = STAT_W'($urandom);
    k = $urandom_range(0, 99);
    if (k < 25) r.cmd = CMD_ENQUEUE;
    else if (k < 45) r.cmd = CMD_DROP;
    else if (k < 65) r.cmd = CMD_PREEMPT;
    else if (k < 82) r.cmd = CMD_YIELD;
    else if (k < 97) r.cmd = CMD_SET_WAKE;
    else r.cmd = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // send a request, holding valid for back-to-back requests of a burst
  task automatic send_req(input sched_req_t r, input bit keep);
    req_if.valid <= 1;
    req_if.cmd <= r.cmd; req_if.thread_id <= r.tid; req_if.now_ns <= r.now;
    req_if.wake_ns <= r.wake; req_if.yield_status <= r.ystat;
    do @(posedge clk_i); while (!req_if.ready);
    pending_reqs.push_back(r);
    if (!keep) req_if.valid <= 0;
  endtask

  // a burst ends with valid dropped before the next request is driven
  task automatic send_burst(input sched_req_t r, inout int left);
    bit keep;
    keep = left > 1 && $urandom_range(0, 3) != 0;
    send_req(r, keep);
    left--;
    if (!keep) repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  // request acceptance: predict the response
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      sched_req_t r;
      r.cmd = req_if.cmd; r.tid = req_if.thread_id; r.now = req_if.now_ns;
      r.wake = req_if.wake_ns; r.ystat = req_if.yield_status;
      expected_rsps.push_back(schedule_step(r));
    end
  end

  // response check
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sched_rsp_t w;
      rsp_count++;
      if (expected_rsps.size() == 0) report_mismatch("unexpected response", 1, 0);
      else begin
        w = expected_rsps.pop_front();
        if (rsp_if.picked_id !== w.picked) report_mismatch("picked_id", rsp_if.picked_id, w.picked);
        if (rsp_if.picked_idle !== w.idle) report_mismatch("picked_idle", rsp_if.picked_idle, w.idle);
        if (rsp_if.result_code !== w.code) report_mismatch("result_code", rsp_if.result_code, w.code);
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk_i) begin
    if (!rx_enable) rsp_if.ready <= 0;
    else if (long_hold) rsp_if.ready <= 0;
    else if (($urandom_range(0, 63) < 32) && (rsp_count % 100 > 60)) rsp_if.ready <= 1;
    else rsp_if.ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog on handshake inactivity
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || long_hold)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // directed table; expected values only for the obvious rows
  sched_req_t dir_req [];
  bit         dir_has [];
  sched_rsp_t dir_rsp [];

  task automatic add_row(input logic [2:0] c, input int t, input logic [63:0] n,
                         input logic [63:0] w, input int y, input bit h, input sched_rsp_t e);
    int i;
    i = dir_req.size();
    dir_req = new [i + 1] (dir_req);
    dir_has = new [i + 1] (dir_has);
    dir_rsp = new [i + 1] (dir_rsp);
    dir_req[i] = '{c, TID_W'(t), n, w, STAT_W'(y)};
    dir_has[i] = h;
    dir_rsp[i] = e;
  endtask

  initial begin
    sched_rsp_t z, e;
    int left, n;
    z = '0;
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    req_if.valid = 0; req_if.cmd = '0; req_if.thread_id = '0;
    req_if.now_ns = '0; req_if.wake_ns = '0; req_if.yield_status = '0;
    model_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    rx_enable <= 1;
    @(posedge clk_i);

    // after reset nothing is queued, a pick returns idle zero
    add_row(CMD_PREEMPT, 0, '1, '0, 0, 1, '{6'd0, 1'b1, RES_DONE});
    add_row(CMD_ENQUEUE, 63, 0, 0, 0, 1, z);
    add_row(CMD_ENQUEUE, 63, 0, 0, 0, 1, '{6'd0, 1'b0, RES_REJECTED});
    add_row(CMD_ENQUEUE, 5, 0, 0, 0, 1, z);
    add_row(CMD_SET_WAKE, 63, 0, '1, 0, 1, z);
    add_row(CMD_SET_WAKE, 5, 0, 64'd100, 0, 1, z);
    // now equal to wake time is not due
    add_row(CMD_YIELD, 0, 64'd100, 0, 2, 1, '{6'd0, 1'b1, RES_DONE});
    add_row(CMD_YIELD, 0, 64'd101, 0, 3, 1, '{6'd5, 1'b0, RES_DONE});
    add_row(CMD_YIELD, 0, '1, 0, 1, 1, '{6'd0, 1'b1, RES_DONE});
    add_row(CMD_DROP, 0, 0, 0, 0, 1, z);           // idle thread drop ignored
    add_row(CMD_DROP, 5, 0, 0, 0, 1, z);
    add_row(CMD_DROP, 5, 0, 0, 0, 1, '{6'd0, 1'b0, RES_REJECTED});
    add_row(CMD_PREEMPT, 0, '1, 0, 0, 0, z);
    for (int i = 0; i < 17; i++) add_row(CMD_PREEMPT, 0, '1, 0, 0, 0, z); // saturation
    add_row(CMD_DROP, 5, 0, 0, 0, 0, z);
    add_row(CMD_PREEMPT, 0, '1, 0, 0, 0, z);
    add_row(3'd5, 42, '1, '1, 3, 1, z);
    add_row(3'd7, 21, 0, 0, 0, 1, z);

    write_idle_id(6'd0);
    fork
      for (int i = 0; i < dir_req.size(); i++) send_req(dir_req[i], i < dir_req.size() - 1);
      for (int i = 0; i < dir_req.size(); i++) begin
        do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
        if (dir_has[i]) begin
          if (rsp_if.picked_id !== dir_rsp[i].picked ||
              rsp_if.picked_idle !== dir_rsp[i].idle ||
              rsp_if.result_code !== dir_rsp[i].code)
            report_mismatch("directed row", i, 0);
        end
      end
    join
    drain();

    // random phases across idle id settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_idle_id(6'd63);
        1: write_idle_id(6'd3);
        2: write_idle_id(6'($urandom));
        default: write_idle_id(6'd0);
      endcase
      if (ph == 1) begin
        fork
          begin
            long_hold = 1;
            repeat (400) @(posedge clk_i);
            long_hold = 0;
          end
        join_none
      end
      left = 225;
      while (left > 0) send_burst(rand_req(), left);
      drain();
    end

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
